/* sv/lrbh_pkg.sv */
// ----------------------------------------------------------------------------
// lrbh_pkg
// Shared widths, register indexes, reset values and the event type passed
// from the run tracker to the record emitter.
// ----------------------------------------------------------------------------
package lrbh_pkg;

    // Field widths.
    localparam int BLOCK_LEN_W   = 14;
    localparam int BLOCK_TOTAL_W = 8;
    localparam int VMIN_W        = 6;
    localparam int CLASS_W       = 3;
    localparam int COUNT_W       = 8;
    localparam int LONGEST_W     = 14;
    localparam int CFG_DATA_W    = 14;
    localparam int CFG_INDEX_W   = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLOCK_LENGTH = 2'd0,
        CFG_BLOCK_TOTAL  = 2'd1,
        CFG_MIN_CLASS    = 2'd2,
        CFG_TOP_CLASS    = 2'd3
    } cfg_index_t;

    // Register reset values.
    localparam logic [BLOCK_LEN_W-1:0]   BLOCK_LENGTH_RST = 14'd8;
    localparam logic [BLOCK_TOTAL_W-1:0] BLOCK_TOTAL_RST  = 8'd16;
    localparam logic [VMIN_W-1:0]        MIN_CLASS_RST    = 6'd1;
    localparam logic [CLASS_W-1:0]       TOP_CLASS_RST    = 3'd3;

    // Record kinds.
    localparam logic REC_BLOCK = 1'b0;
    localparam logic REC_COUNT = 1'b1;

    // Saturation limit of a class counter.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // Block-end event from the tracker to the emitter.
    typedef struct packed {
        logic                 load;
        logic [LONGEST_W-1:0] longest;
        logic [CLASS_W-1:0]   cls;
        logic [CLASS_W-1:0]   top;
        logic                 seq_end;
    } lrbh_evt_t;

endpackage

/* sv/lrbh_bit_if.sv */
// ----------------------------------------------------------------------------
// lrbh_bit_if
// Input channel: one bit of the sequence under test per transaction.
// ----------------------------------------------------------------------------
interface lrbh_bit_if;
    logic valid;
    logic ready;
    logic bit_value;

    modport source (output valid, output bit_value, input ready);
    modport sink   (input valid, input bit_value, output ready);
endinterface

/* sv/lrbh_rec_if.sv */
// ----------------------------------------------------------------------------
// lrbh_rec_if
// Output channel: one block record or class count record per transaction.
// ----------------------------------------------------------------------------
interface lrbh_rec_if;
    import lrbh_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 record_kind;
    logic [LONGEST_W-1:0] block_longest;
    logic [CLASS_W-1:0]   class_index;
    logic [COUNT_W-1:0]   class_count;
    logic                 last_record;

    modport source (output valid, output record_kind, output block_longest,
                    output class_index, output class_count, output last_record,
                    input ready);
    modport sink   (input valid, input record_kind, input block_longest,
                    input class_index, input class_count, input last_record,
                    output ready);
endinterface

/* sv/lrbh_cfg_if.sv */
// ----------------------------------------------------------------------------
// lrbh_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lrbh_cfg_if;
    import lrbh_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/lrbh_core.sv */
// ----------------------------------------------------------------------------
// lrbh_core
// Configuration registers, run tracking, block classification and the
// class counters. Raises a block-end event toward the emitter.
// ----------------------------------------------------------------------------
module lrbh_core #(
    parameter int MAX_CLASSES = 7,
    parameter int RUN_WIDTH   = 14
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    lrbh_cfg_if.sink                                   cfg,
    lrbh_bit_if.sink                                   bit_in,
    input  logic                                       emit_free,
    output lrbh_pkg::lrbh_evt_t                        evt,
    output logic [MAX_CLASSES-1:0][lrbh_pkg::COUNT_W-1:0] counts
);
    import lrbh_pkg::*;

    localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CMP_W = ((RUN_WIDTH > VMIN_W + 1) ? RUN_WIDTH : VMIN_W + 1) + 1;
    localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

    logic [BLOCK_LEN_W-1:0]   block_length_reg;
    logic [BLOCK_TOTAL_W-1:0] block_total_reg;
    logic [VMIN_W-1:0]        min_class_reg;
    logic [CLASS_W-1:0]       top_class_reg;

    logic [BLOCK_LEN_W-1:0]   bit_position_reg;
    logic [RUN_WIDTH-1:0]     current_run_reg;
    logic [RUN_WIDTH-1:0]     longest_run_reg;
    logic [BLOCK_TOTAL_W-1:0] blocks_done_reg;
    logic [COUNT_W-1:0]       class_counters_reg [MAX_CLASSES];

    logic [BLOCK_LEN_W:0]     pos_next;
    logic                     block_end;
    logic                     accept;
    logic [RUN_WIDTH-1:0]     run_next;
    logic [RUN_WIDTH-1:0]     longest_next;
    logic [BLOCK_TOTAL_W-1:0] blocks_next;
    logic                     seq_end;
    logic [CLASS_W-1:0]       top_eff;
    logic [CLASS_W-1:0]       cls;
    logic [CLS_W-1:0]         cls_idx;
    logic [CMP_W-1:0]         lng_ext;
    logic [CMP_W-1:0]         vmin_ext;
    logic [CMP_W-1:0]         upper_ext;

    assign cfg.ready = 1'b1;

    // Block end is known from the position alone, so ready never looks at data.
    assign pos_next  = {1'b0, bit_position_reg} + 1'b1;
    assign block_end = pos_next >= {1'b0, block_length_reg};
    assign bit_in.ready = !block_end || emit_free;
    assign accept = bit_in.valid && bit_in.ready;

    // Run update with saturation.
    always_comb
    begin
        if (!bit_in.bit_value)
            run_next = '0;
        else if (current_run_reg == RUN_MAX)
            run_next = current_run_reg;
        else
            run_next = current_run_reg + 1'b1;
        longest_next = (run_next > longest_run_reg) ? run_next : longest_run_reg;
    end

    // Effective top class, capped by the number of counters.
    always_comb
    begin
        if (int'(top_class_reg) > MAX_CLASSES - 1)
            top_eff = CLASS_W'(MAX_CLASSES - 1);
        else
            top_eff = top_class_reg;
    end

    // Classification of the finished block.
    always_comb
    begin
        lng_ext   = CMP_W'(longest_next);
        vmin_ext  = CMP_W'(min_class_reg);
        upper_ext = vmin_ext + CMP_W'(top_eff);
        if (lng_ext <= vmin_ext)
            cls = '0;
        else if (lng_ext >= upper_ext)
            cls = top_eff;
        else
            cls = CLASS_W'(lng_ext - vmin_ext);
        cls_idx = CLS_W'(cls);
    end

    // Sequence bookkeeping; block_total of zero ends every block's sequence.
    assign blocks_next = blocks_done_reg + 1'b1;
    assign seq_end = (blocks_next >= block_total_reg) || (blocks_next == '0);

    // Counters after this block's increment, before any clear.
    always_comb
    begin
        for (int i = 0; i < MAX_CLASSES; i++)
        begin
            if (CLS_W'(i) == cls_idx && class_counters_reg[i] != COUNT_MAX)
                counts[i] = class_counters_reg[i] + 1'b1;
            else
                counts[i] = class_counters_reg[i];
        end
    end

    // Event toward the emitter.
    assign evt.load    = accept && block_end;
    assign evt.longest = LONGEST_W'(longest_next);
    assign evt.cls     = cls;
    assign evt.top     = top_eff;
    assign evt.seq_end = seq_end;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= BLOCK_LENGTH_RST;
            block_total_reg  <= BLOCK_TOTAL_RST;
            min_class_reg    <= MIN_CLASS_RST;
            top_class_reg    <= TOP_CLASS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_BLOCK_LENGTH: block_length_reg <= cfg.data[BLOCK_LEN_W-1:0];
                CFG_BLOCK_TOTAL:  block_total_reg  <= cfg.data[BLOCK_TOTAL_W-1:0];
                CFG_MIN_CLASS:    min_class_reg    <= cfg.data[VMIN_W-1:0];
                CFG_TOP_CLASS:    top_class_reg    <= cfg.data[CLASS_W-1:0];
            endcase
        end
    end

    // Run and block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_position_reg <= '0;
            current_run_reg  <= '0;
            longest_run_reg  <= '0;
            blocks_done_reg  <= '0;
            for (int i = 0; i < MAX_CLASSES; i++)
                class_counters_reg[i] <= '0;
        end
        else if (accept)
        begin
            if (!block_end)
            begin
                bit_position_reg <= pos_next[BLOCK_LEN_W-1:0];
                current_run_reg  <= run_next;
                longest_run_reg  <= longest_next;
            end
            else
            begin
                bit_position_reg <= '0;
                current_run_reg  <= '0;
                longest_run_reg  <= '0;
                blocks_done_reg  <= seq_end ? '0 : blocks_next;
                for (int i = 0; i < MAX_CLASSES; i++)
                    class_counters_reg[i] <= seq_end ? '0 : counts[i];
            end
        end
    end

`ifndef ASSERT_OFF
    // The longest run always covers the run in progress.
    a_longest_covers_run: assert property (@(posedge clk) disable iff (!rst_n)
        longest_run_reg >= current_run_reg)
        else $error("longest run below current run");

    // A sequence end restarts the block count.
    a_seq_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && block_end && seq_end) |=> (blocks_done_reg == '0))
        else $error("blocks done not cleared at sequence end");

    // A bit that ends a block is only taken when the emitter has room.
    a_end_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && block_end) |-> emit_free)
        else $error("block end accepted without emitter room");
`endif

endmodule

/* sv/lrbh_emit.sv */
// ----------------------------------------------------------------------------
// lrbh_emit
// Result register: holds one block event and a counter snapshot, then sends
// the block record and, at a sequence end, the class count records.
// ----------------------------------------------------------------------------
module lrbh_emit #(
    parameter int MAX_CLASSES = 7
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  lrbh_pkg::lrbh_evt_t                           evt,
    input  logic [MAX_CLASSES-1:0][lrbh_pkg::COUNT_W-1:0] counts,
    output logic                                          emit_free,
    lrbh_rec_if.source                                    rec
);
    import lrbh_pkg::*;

    localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int SLOT_W = $clog2(MAX_CLASSES + 1);

    logic                 busy_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [LONGEST_W-1:0] longest_reg;
    logic [CLASS_W-1:0]   cls_reg;
    logic [CLASS_W-1:0]   top_reg;
    logic                 seq_end_reg;
    logic [COUNT_W-1:0]   snap_reg [MAX_CLASSES];

    logic                 fire;
    logic                 at_last;
    logic [CLASS_W-1:0]   count_cls;
    logic [CLS_W-1:0]     snap_idx;

    // Slot zero is the block record; slot s reports class s-1.
    assign count_cls = CLASS_W'(slot_reg - 1'b1);
    assign snap_idx  = (slot_reg == '0) ? '0 : CLS_W'(slot_reg - 1'b1);
    assign at_last   = (slot_reg == '0) ? !seq_end_reg : (count_cls == top_reg);
    assign fire      = rec.valid && rec.ready;
    assign emit_free = !busy_reg || (fire && at_last);

    // Output payload.
    assign rec.valid         = busy_reg;
    assign rec.record_kind   = (slot_reg == '0) ? REC_BLOCK : REC_COUNT;
    assign rec.block_longest = (slot_reg == '0) ? longest_reg : '0;
    assign rec.class_index   = (slot_reg == '0) ? cls_reg : count_cls;
    assign rec.class_count   = (slot_reg == '0) ? '0 : snap_reg[snap_idx];
    assign rec.last_record   = (slot_reg != '0) && (count_cls == top_reg);

    // Record sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end
        else if (evt.load)
        begin
            busy_reg <= 1'b1;
            slot_reg <= '0;
        end
        else if (fire)
        begin
            if (at_last)
                busy_reg <= 1'b0;
            else
                slot_reg <= slot_reg + 1'b1;
        end
    end

    // Event payload and counter snapshot.
    always_ff @(posedge clk)
    begin
        if (evt.load)
        begin
            longest_reg <= evt.longest;
            cls_reg     <= evt.cls;
            top_reg     <= evt.top;
            seq_end_reg <= evt.seq_end;
            for (int i = 0; i < MAX_CLASSES; i++)
                snap_reg[i] <= counts[i];
        end
    end

`ifndef ASSERT_OFF
    // A new event only lands when the current one is done.
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        evt.load |-> (!busy_reg || (fire && at_last)))
        else $error("event loaded over pending records");

    // The count slot never passes the top class.
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && slot_reg != '0) |-> ((slot_reg - 1'b1) <= SLOT_W'(top_reg)))
        else $error("count slot beyond top class");

    // The last record drains the emitter unless a new event follows.
    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && at_last && !evt.load) |=> !rec.valid)
        else $error("records continue past the last one");
`endif

endmodule

/* sv/longest_run_block_histogram.sv */
// ----------------------------------------------------------------------------
// longest_run_block_histogram
// Longest run of ones per block with a class histogram per sequence.
// ----------------------------------------------------------------------------
// One bit is taken per clock cycle, except that a bit that ends a block waits
// while the emitter still has records pending. A bit inside a block is taken
// every cycle regardless of the output side. A bit that ends a block loads
// the result register with the block event and a counter snapshot; at the
// end of a sequence the emitter then sends 1 + K + 1 records, one per cycle
// while the output is ready. The next block-ending bit is taken in the cycle
// the last of those records is delivered. There is no clearing pass after
// reset.
module longest_run_block_histogram #(
    parameter int MAX_CLASSES = 7,
    parameter int RUN_WIDTH   = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    lrbh_cfg_if.sink   cfg,
    lrbh_bit_if.sink   bit_in,
    lrbh_rec_if.source rec_out
);
    import lrbh_pkg::*;

    lrbh_evt_t                        evt;
    logic [MAX_CLASSES-1:0][COUNT_W-1:0] counts;
    logic                             emit_free;

    // Run tracking, classification and counters.
    lrbh_core #(
        .MAX_CLASSES (MAX_CLASSES),
        .RUN_WIDTH   (RUN_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .bit_in    (bit_in),
        .emit_free (emit_free),
        .evt       (evt),
        .counts    (counts)
    );

    // Result register and record sequencing.
    lrbh_emit #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .counts    (counts),
        .emit_free (emit_free),
        .rec       (rec_out)
    );

endmodule
